// ===== rtl/bfpwc_pkg.sv =====
// package: constants, types and helpers for the block floating point weight compressor
package bfpwc_pkg;

    localparam int MAX_WEIGHTS = 64;
    localparam int QUANT_BITS  = 16;

    localparam int CNT_W  = $clog2(MAX_WEIGHTS + 1);
    localparam int ADDR_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
    localparam int ACC_W  = 96;
    localparam int WORD_W = 64;

    localparam logic [4:0]  WIDTH_RESET = 5'd9;
    localparam logic [4:0]  WIDTH_MAX   = 5'd16;
    localparam logic signed [15:0] MAX_RESET = 16'sh8000;
    localparam logic signed [15:0] MIN_RESET = 16'sh7FFF;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_PACK,
        ST_FLUSH
    } state_t;

    function automatic logic signed [15:0] quant_value(input logic [15:0] raw);
        logic signed [QUANT_BITS-1:0] t;
        t = raw[QUANT_BITS-1:0];
        return 16'(t);
    endfunction

endpackage

// ===== rtl/bfp_weight_compressor.sv =====
// top level: block floating point compression of one beamforming weight vector
//
// s_ channel: one weight per item, s_tdata = {quadrature, inphase}, s_tlast marks the
// last weight of the vector. Weights load at one item per cycle into a 64-entry store
// while a running maximum and minimum are kept; weights beyond the store size are dropped.
// After the last item the block stops taking items, finds the exponent, then reads the store
// (single read port, registered read) one weight per cycle unless a full word waits on a
// stalled receiver; it packs the exponent byte and shifted values MSB first into 64-bit words.
// m_ channel: m_tdata carries up to eight stream bytes, first byte in the top byte,
// m_tuser the count of valid leading bytes, m_tlast the last word of the block.
// The input reopens once the last word of the block is in the output register. Every word
// but the last leaves only once 64 bits are gathered, so at narrow widths the first word
// comes later. Results sit in an output register: when the receiver stalls and a full word
// is due, the packing step holds and the store read is not advanced; the next vector may
// begin loading while the last word still waits. cfg_wr_en writes sample_width (reset 9,
// 0 treated as 1, above 16 as 16). Reset (aresetn low, synchronous) empties the store,
// clears the running extremes and drops any pending result.
module bfp_weight_compressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // sample_width
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // inphase [15:0], quadrature [31:16]
    input  logic        s_tlast,       // final_weight
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // packed_word
    output logic [3:0]  m_tuser,       // byte_count
    output logic        m_tlast        // end_of_block
);
    import bfpwc_pkg::*;

    logic [31:0] store_mem [0:MAX_WEIGHTS-1];

    state_t state_reg, state_next;
    logic [4:0] width_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic signed [15:0] max_reg, max_next, min_reg, min_next;
    logic [4:0] exp_reg, exp_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [6:0] acc_bits_reg, acc_bits_next;
    logic [31:0] rd_data_reg;
    logic m_tvalid_reg, m_tvalid_next, m_tlast_reg, m_tlast_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic [3:0] m_tuser_reg, m_tuser_next;

    logic in_accept, wr_en, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [15:0] iv, qv, mx1, mn1;
    logic [4:0] w_eff;
    logic slot_free;

    // exponent
    logic signed [16:0] neg_val, mx_val;
    logic [3:0] bit_len;
    logic [4:0] e_calc;

    // packing
    logic signed [15:0] i_val, q_val;
    logic [15:0] i_bits, q_bits, w_mask;
    logic [31:0] pair_bits;
    logic [6:0] sum_bits, place_sh, bits_left;
    logic [ACC_W-1:0] acc_app, acc_left;
    logic need_push, last_pair, can_step;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_LOAD);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign iv = quant_value(s_tdata[15:0]);
    assign qv = quant_value(s_tdata[31:16]);
    assign wr_en = in_accept && (cnt_reg < CNT_W'(MAX_WEIGHTS));

    always_comb begin
        if (width_reg == 5'd0) begin
            w_eff = 5'd1;
        end else if (width_reg > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = width_reg;
        end
    end

    always_comb begin
        mx1 = (iv > max_reg) ? iv : max_reg;
        mx1 = (qv > mx1) ? qv : mx1;
        mn1 = (iv < min_reg) ? iv : min_reg;
        mn1 = (qv < mn1) ? qv : mn1;
    end

    always_comb begin
        if (min_reg < 0) begin
            neg_val = 17'($unsigned(~min_reg));
        end else begin
            neg_val = 17'(min_reg) - 17'sd1;
        end
        mx_val = (17'(max_reg) > neg_val) ? 17'(max_reg) : neg_val;
        bit_len = 4'd0;
        for (int b = 0; b < 15; b++) begin
            if (mx_val[b]) begin
                bit_len = 4'(b + 1);
            end
        end
        if (mx_val <= 0) begin
            e_calc = 5'd0;
        end else if ((5'(bit_len) + 5'd1) > w_eff) begin
            e_calc = 5'(bit_len) + 5'd1 - w_eff;
        end else begin
            e_calc = 5'd0;
        end
    end

    always_comb begin
        i_val = rd_data_reg[31:16];
        q_val = rd_data_reg[15:0];
        w_mask = 16'((17'd1 << w_eff) - 17'd1);
        i_bits = 16'(i_val >>> exp_reg) & w_mask;
        q_bits = 16'(q_val >>> exp_reg) & w_mask;
        pair_bits = (32'(i_bits) << w_eff) | 32'(q_bits);
        sum_bits = acc_bits_reg + {1'b0, w_eff, 1'b0};
        place_sh = 7'(ACC_W) - sum_bits;
        acc_app = acc_reg | (ACC_W'(pair_bits) << place_sh);
        acc_left = acc_app << WORD_W;
        bits_left = sum_bits - 7'(WORD_W);
        need_push = (sum_bits >= 7'(WORD_W));
        last_pair = (rd_idx_reg == cnt_reg);
        can_step = !need_push || slot_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_accept && s_tlast) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_PACK;
            end
            ST_PACK: begin
                if (can_step && last_pair) begin
                    state_next = (need_push && bits_left == 7'd0) ? ST_LOAD : ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next = cnt_reg;
        max_next = max_reg;
        min_next = min_reg;
        rd_idx_next = rd_idx_reg;
        exp_next = exp_reg;
        acc_next = acc_reg;
        acc_bits_next = acc_bits_reg;
        rd_en = 1'b0;
        rd_addr = rd_idx_reg[ADDR_W-1:0];
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tlast_next = m_tlast_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (wr_en) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    max_next = mx1;
                    min_next = mn1;
                end
            end
            ST_CALC: begin
                exp_next = e_calc;
                acc_next = {3'b000, e_calc, {(ACC_W-8){1'b0}}};
                acc_bits_next = 7'd8;
                rd_en = 1'b1;
                rd_addr = '0;
                rd_idx_next = CNT_W'(1);
            end
            ST_PACK: begin
                if (can_step) begin
                    if (need_push) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next = acc_app[ACC_W-1 -: WORD_W];
                        m_tuser_next = 4'd8;
                        m_tlast_next = last_pair && (bits_left == 7'd0);
                        acc_next = acc_left;
                        acc_bits_next = bits_left;
                    end else begin
                        acc_next = acc_app;
                        acc_bits_next = sum_bits;
                    end
                    if (!last_pair) begin
                        rd_en = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end else if (need_push && bits_left == 7'd0) begin
                        cnt_next = '0;
                        max_next = MAX_RESET;
                        min_next = MIN_RESET;
                    end
                end
            end
            ST_FLUSH: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = acc_reg[ACC_W-1 -: WORD_W];
                    m_tuser_next = 4'((acc_bits_reg + 7'd7) >> 3);
                    m_tlast_next = 1'b1;
                    cnt_next = '0;
                    max_next = MAX_RESET;
                    min_next = MIN_RESET;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[cnt_reg[ADDR_W-1:0]] <= {iv, qv};
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            width_reg <= WIDTH_RESET;
            cnt_reg <= '0;
            rd_idx_reg <= '0;
            max_reg <= MAX_RESET;
            min_reg <= MIN_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            cnt_reg <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            max_reg <= max_next;
            min_reg <= min_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg <= exp_next;
        acc_reg <= acc_next;
        acc_bits_reg <= acc_bits_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_WEIGHTS))
        else $error("pair count beyond store size");

    a_last_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tlast |=> state_reg == ST_CALC)
        else $error("last item did not start the exponent step");

    a_pack_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PACK |-> rd_idx_reg != '0 && rd_idx_reg <= cnt_reg)
        else $error("store read index out of range");

    a_acc_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PACK || state_reg == ST_FLUSH |-> acc_bits_reg < 7'(WORD_W))
        else $error("bit accumulator overfilled");

    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tlast_reg |-> m_tuser_reg == 4'd8)
        else $error("partial word before end of block");

endmodule
